FILE: rtl/gamt_pkg.sv
// Shared constants and types for the gyro angle and magnetometer range tracker.
package gamt_pkg;

  localparam int MAG_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  // gyro step carries ten integer bits, the wrapped angle nine
  localparam int GYRO_EXTRA  = 10;
  localparam int ANGLE_EXTRA = 9;
  localparam int TURN_DEG    = 360;

  localparam int SUM_EXTRA = 32;
  localparam int CNT_W     = 31;
  localparam logic [CNT_W-1:0] HALVE_LIMIT = CNT_W'(1) << 30;

  localparam int WARM_W     = 16;
  localparam int AXIS_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [WARM_W-1:0] WARMUP_RESET = WARM_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARMUP = 2'd0,
    REG_AXIS   = 2'd1
  } cfg_reg_t;

  typedef logic [AXIS_W-1:0] axis_sel_t;
  localparam axis_sel_t AXIS_Y = 2'd1;
  localparam axis_sel_t AXIS_Z = 2'd2;

endpackage

FILE: rtl/gamt_angle.sv
// One angle accumulator: add a gyro step, then fold back into one turn.
module gamt_angle #(
  parameter int FRAC_BITS = gamt_pkg::FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            load,
  input  logic                                            fix_en,
  input  logic signed [FRAC_BITS+gamt_pkg::GYRO_EXTRA-1:0] step,
  output logic [FRAC_BITS+gamt_pkg::ANGLE_EXTRA-1:0]       angle
);
  import gamt_pkg::*;

  localparam int GYRO_W  = FRAC_BITS + GYRO_EXTRA;
  localparam int ANGLE_W = FRAC_BITS + ANGLE_EXTRA;
  localparam int WORK_W  = GYRO_W + 1;
  localparam logic signed [WORK_W-1:0] TURN = WORK_W'(TURN_DEG) << FRAC_BITS;

  logic signed [WORK_W-1:0] acc_r, acc_nxt;

  // a sum can sit up to two turns out of range; each fix step moves one turn
  always_comb begin
    acc_nxt = acc_r;
    if (load) begin
      acc_nxt = acc_r + WORK_W'(step);
    end else if (fix_en) begin
      if (acc_r < 0) begin
        acc_nxt = acc_r + TURN;
      end else if (acc_r >= TURN) begin
        acc_nxt = acc_r - TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign angle = acc_r[ANGLE_W-1:0];

endmodule

FILE: rtl/gamt_div.sv
// Bit-serial restoring divider: signed sum over unsigned count, truncated toward zero.
module gamt_div #(
  parameter int SUM_W = gamt_pkg::MAG_WIDTH_DEF + gamt_pkg::SUM_EXTRA,
  parameter int QUO_W = gamt_pkg::MAG_WIDTH_DEF + 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [SUM_W-1:0]          dividend,
  input  logic [gamt_pkg::CNT_W-1:0]       divisor,
  output logic                             done,
  output logic signed [QUO_W-1:0]          quotient
);
  import gamt_pkg::*;

  localparam int REM_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(QUO_W);

  logic [SUM_W-1:0]  mag;
  logic [REM_W-1:0]  rem_r;
  logic [QUO_W-1:0]  dq_r;
  logic [CNT_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  // shift the next dividend bit in from the top of the quotient register
  assign trial = {rem_r[REM_W-2:0], dq_r[QUO_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(QUO_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(mag >> QUO_W);
      dq_r  <= mag[QUO_W-1:0];
      div_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? trial - {1'b0, div_r} : trial;
      dq_r  <= {dq_r[QUO_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(dq_r) : $signed(dq_r);

endmodule

FILE: rtl/gyro_angle_and_mag_range_tracker.sv
// Top level: gyro angle integration and magnetometer min/avg/max tracking.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall  | gyro_vld, gyro_x/y/z, mag_vld, mag_x/y/z
//  out_    | output    | out_valid / out_stall| angle_x/y/z, stats_report/ready, stat_min/avg/max
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each request passes from accept to result through the start, divide and final states;
// the bit-serial divider forms the average one quotient bit a cycle.
// Angle wrap-around runs alongside the divider and is done well before it.
// Reset is synchronous and clears angles, warmup count and all statistics.
// A new request is taken while the previous result still waits on out_stall;
// it then holds in the final state until the output register frees.
module gyro_angle_and_mag_range_tracker #(
  parameter int MAG_WIDTH = gamt_pkg::MAG_WIDTH_DEF,
  parameter int FRAC_BITS = gamt_pkg::FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_valid,
  output logic                                            in_stall,
  input  logic                                            in_gyro_vld,
  input  logic signed [FRAC_BITS+gamt_pkg::GYRO_EXTRA-1:0] in_gyro_x,
  input  logic signed [FRAC_BITS+gamt_pkg::GYRO_EXTRA-1:0] in_gyro_y,
  input  logic signed [FRAC_BITS+gamt_pkg::GYRO_EXTRA-1:0] in_gyro_z,
  input  logic                                            in_mag_vld,
  input  logic signed [MAG_WIDTH-1:0]                     in_mag_x,
  input  logic signed [MAG_WIDTH-1:0]                     in_mag_y,
  input  logic signed [MAG_WIDTH-1:0]                     in_mag_z,
  output logic                                            out_valid,
  input  logic                                            out_stall,
  output logic [FRAC_BITS+gamt_pkg::ANGLE_EXTRA-1:0]       out_angle_x,
  output logic [FRAC_BITS+gamt_pkg::ANGLE_EXTRA-1:0]       out_angle_y,
  output logic [FRAC_BITS+gamt_pkg::ANGLE_EXTRA-1:0]       out_angle_z,
  output logic                                            out_stats_report,
  output logic                                            out_stats_ready,
  output logic signed [MAG_WIDTH-1:0]                     out_stat_min,
  output logic signed [MAG_WIDTH-1:0]                     out_stat_avg,
  output logic signed [MAG_WIDTH-1:0]                     out_stat_max,
  input  logic                                            cfg_valid,
  output logic                                            cfg_ready,
  input  logic [gamt_pkg::CFG_IDX_W-1:0]                  cfg_index,
  input  logic [gamt_pkg::CFG_DATA_W-1:0]                 cfg_data
);
  import gamt_pkg::*;

  localparam int GYRO_W  = FRAC_BITS + GYRO_EXTRA;
  localparam int ANGLE_W = FRAC_BITS + ANGLE_EXTRA;
  localparam int SUM_W   = MAG_WIDTH + SUM_EXTRA;
  localparam int QUO_W   = MAG_WIDTH + 1;
  localparam logic [ANGLE_W-1:0] TURN = ANGLE_W'(TURN_DEG) << FRAC_BITS;

  typedef enum logic [1:0] {S_IDLE, S_START, S_DIVIDE, S_FIN} state_t;

  state_t state_r;

  logic [WARM_W-1:0] warmup_r;
  axis_sel_t         axis_r;
  logic [1:0]        ax;

  logic                    in_acc;
  logic                    mag_report_r;
  logic signed [MAG_WIDTH-1:0] mag_v [3];
  logic signed [GYRO_W-1:0]    gyro_v [3];
  logic [ANGLE_W-1:0]          angle_v [3];

  logic [WARM_W-1:0]           warm_cnt_r, warm_cnt_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt, cnt_inc;
  logic signed [MAG_WIDTH-1:0] min_r [3], min_nxt [3];
  logic signed [MAG_WIDTH-1:0] max_r [3], max_nxt [3];
  logic signed [SUM_W-1:0]     sum_r [3], sum_nxt [3], sum_add [3];
  logic                        halve;

  logic                    div_start;
  logic                    div_done;
  logic signed [QUO_W-1:0] div_quo;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign div_start = state_r == S_START;

  assign mag_v[0]  = in_mag_x;
  assign mag_v[1]  = in_mag_y;
  assign mag_v[2]  = in_mag_z;
  assign gyro_v[0] = in_gyro_x;
  assign gyro_v[1] = in_gyro_y;
  assign gyro_v[2] = in_gyro_z;

  always_comb begin
    unique case (axis_r)
      AXIS_Y:  ax = 2'd1;
      AXIS_Z:  ax = 2'd2;
      default: ax = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r <= WARMUP_RESET;
      axis_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WARMUP: warmup_r <= cfg_data[WARM_W-1:0];
        REG_AXIS:   axis_r   <= cfg_data[AXIS_W-1:0];
        default:    ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_angle
      gamt_angle #(
        .FRAC_BITS (FRAC_BITS)
      ) u_angle (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_acc && in_gyro_vld),
        .fix_en (state_r != S_IDLE),
        .step   (gyro_v[g]),
        .angle  (angle_v[g])
      );
    end
  endgenerate

  // statistics update happens in the accept cycle
  always_comb begin
    warm_cnt_nxt = warm_cnt_r;
    cnt_nxt      = cnt_r;
    cnt_inc      = cnt_r + 1'b1;
    halve        = cnt_inc > HALVE_LIMIT;
    for (int i = 0; i < 3; i++) begin
      min_nxt[i] = min_r[i];
      max_nxt[i] = max_r[i];
      sum_nxt[i] = sum_r[i];
      sum_add[i] = sum_r[i] + SUM_W'(mag_v[i]);
    end
    if (in_acc && in_mag_vld) begin
      if (warm_cnt_r < warmup_r) begin
        warm_cnt_nxt = warm_cnt_r + 1'b1;
      end else begin
        cnt_nxt = halve ? cnt_inc >> 1 : cnt_inc;
        for (int i = 0; i < 3; i++) begin
          if (cnt_r == '0 || mag_v[i] < min_r[i]) begin
            min_nxt[i] = mag_v[i];
          end
          if (cnt_r == '0 || mag_v[i] > max_r[i]) begin
            max_nxt[i] = mag_v[i];
          end
          sum_nxt[i] = halve ? sum_add[i] >>> 1 : sum_add[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r <= '0;
      cnt_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= '0;
        max_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      warm_cnt_r <= warm_cnt_nxt;
      cnt_r      <= cnt_nxt;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= min_nxt[i];
        max_r[i] <= max_nxt[i];
        sum_r[i] <= sum_nxt[i];
      end
    end
  end

  gamt_div #(
    .SUM_W (SUM_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[ax]),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in the final state the output register is reloaded whenever it frees
      if (!out_stall && state_r != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r      <= S_START;
            mag_report_r <= in_mag_vld;
          end
        end
        S_START: state_r <= S_DIVIDE;
        S_DIVIDE: begin
          if (div_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the finished request until the output register frees
          if (!out_valid || !out_stall) begin
            state_r          <= S_IDLE;
            out_valid        <= 1'b1;
            out_angle_x      <= angle_v[0];
            out_angle_y      <= angle_v[1];
            out_angle_z      <= angle_v[2];
            out_stats_report <= mag_report_r;
            out_stats_ready  <= cnt_r != '0;
            out_stat_min     <= min_r[ax];
            out_stat_max     <= max_r[ax];
            out_stat_avg     <= (cnt_r == '0) ? '0 : div_quo[MAG_WIDTH-1:0];
          end
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= HALVE_LIMIT)
    else $error("sample count above halving limit");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stats_ready |->
      out_stat_min == '0 && out_stat_avg == '0 && out_stat_max == '0)
    else $error("statistics nonzero before any counted sample");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_x < TURN && out_angle_y < TURN && out_angle_z < TURN)
    else $error("angle outside one turn");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVIDE)
    else $error("divider finished outside divide state");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_START)
    else $error("accepted request did not start");
`endif

endmodule

FILE: dv/gamt_checker.sv
// Checker: predicts each result of the angle and range tracker and compares it with the DUT.
`timescale 1ns / 1ps

module gamt_checker (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 in_valid,
  input  logic                                                 in_stall,
  input  logic                                                 in_gyro_vld,
  input  logic [gamt_pkg::FRAC_BITS_DEF+gamt_pkg::GYRO_EXTRA-1:0]  in_gyro_x,
  input  logic [gamt_pkg::FRAC_BITS_DEF+gamt_pkg::GYRO_EXTRA-1:0]  in_gyro_y,
  input  logic [gamt_pkg::FRAC_BITS_DEF+gamt_pkg::GYRO_EXTRA-1:0]  in_gyro_z,
  input  logic                                                 in_mag_vld,
  input  logic [gamt_pkg::MAG_WIDTH_DEF-1:0]                   in_mag_x,
  input  logic [gamt_pkg::MAG_WIDTH_DEF-1:0]                   in_mag_y,
  input  logic [gamt_pkg::MAG_WIDTH_DEF-1:0]                   in_mag_z,
  input  logic                                                 out_valid,
  input  logic                                                 out_stall,
  input  logic [gamt_pkg::FRAC_BITS_DEF+gamt_pkg::ANGLE_EXTRA-1:0] out_angle_x,
  input  logic [gamt_pkg::FRAC_BITS_DEF+gamt_pkg::ANGLE_EXTRA-1:0] out_angle_y,
  input  logic [gamt_pkg::FRAC_BITS_DEF+gamt_pkg::ANGLE_EXTRA-1:0] out_angle_z,
  input  logic                                                 out_stats_report,
  input  logic                                                 out_stats_ready,
  input  logic [gamt_pkg::MAG_WIDTH_DEF-1:0]                   out_stat_min,
  input  logic [gamt_pkg::MAG_WIDTH_DEF-1:0]                   out_stat_avg,
  input  logic [gamt_pkg::MAG_WIDTH_DEF-1:0]                   out_stat_max,
  input  logic                                                 cfg_valid,
  input  logic                                                 cfg_ready,
  input  logic [gamt_pkg::CFG_IDX_W-1:0]                       cfg_index,
  input  logic [gamt_pkg::CFG_DATA_W-1:0]                      cfg_data,
  output int                                                   fail_count,
  output int                                                   pending
);
  import gamt_pkg::*;

  localparam int     GYRO_W    = FRAC_BITS_DEF + GYRO_EXTRA;
  localparam int     ANGLE_W   = FRAC_BITS_DEF + ANGLE_EXTRA;
  localparam int     MAG_W     = MAG_WIDTH_DEF;
  localparam longint TURN      = longint'(TURN_DEG) << FRAC_BITS_DEF;
  localparam int     MAX_PRINT = 100;

  typedef struct packed {
    logic [2:0][ANGLE_W-1:0] angle;
    logic                    report;
    logic                    ready;
    logic [MAG_W-1:0]        min_v;
    logic [MAG_W-1:0]        avg_v;
    logic [MAG_W-1:0]        max_v;
  } tracker_report_t;

  tracker_report_t   expected_reports[$];
  tracker_report_t   want_r;
  tracker_report_t   seen_r;

  logic [WARM_W-1:0] warmup_limit;
  axis_sel_t         axis_reg;
  longint            angle_acc[3];
  logic [WARM_W-1:0] warmup_seen;
  longint            axis_min[3];
  longint            axis_max[3];
  longint            axis_sum[3];
  longint            sample_count;
  int                errs = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Advance the tracker state by one request and form the report it yields.
  function automatic tracker_report_t track_request(
    input logic                    imu,
    input logic [2:0][GYRO_W-1:0]  gyro,
    input logic                    mag,
    input logic [2:0][MAG_W-1:0]   mags
  );
    tracker_report_t res;
    longint          s;
    longint          v;
    longint          avg;
    int              ax;
    int              i;
    if (imu) begin
      for (i = 0; i < 3; i++) begin
        s = (angle_acc[i] + longint'($signed(gyro[i]))) % TURN;
        if (s < 0) s += TURN;
        angle_acc[i] = s;
      end
    end
    if (mag) begin
      if (warmup_seen < warmup_limit) begin
        warmup_seen++;
      end else begin
        for (i = 0; i < 3; i++) begin
          v = longint'($signed(mags[i]));
          if (sample_count == 0) begin
            axis_min[i] = v;
            axis_max[i] = v;
          end else begin
            if (v < axis_min[i]) axis_min[i] = v;
            if (v > axis_max[i]) axis_max[i] = v;
          end
          axis_sum[i] += v;
        end
        sample_count++;
        // halve the count and sums once the count passes the limit
        if (sample_count > longint'(HALVE_LIMIT)) begin
          sample_count = sample_count >> 1;
          for (i = 0; i < 3; i++) axis_sum[i] = axis_sum[i] >>> 1;
        end
      end
    end
    ax = (axis_reg > AXIS_Z) ? 0 : int'(axis_reg);
    avg = (sample_count != 0) ? axis_sum[ax] / sample_count : 0;
    for (i = 0; i < 3; i++) res.angle[i] = ANGLE_W'(angle_acc[i]);
    res.report = mag;
    res.ready  = (sample_count != 0);
    res.min_v  = MAG_W'(axis_min[ax]);
    res.avg_v  = MAG_W'(avg);
    res.max_v  = MAG_W'(axis_max[ax]);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (seen !== want) begin
      errs++;
      if (errs <= MAX_PRINT)
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      warmup_limit = WARMUP_RESET;
      axis_reg     = '0;
      warmup_seen  = '0;
      sample_count = 0;
      for (int i = 0; i < 3; i++) begin
        angle_acc[i] = 0;
        axis_min[i]  = 0;
        axis_max[i]  = 0;
        axis_sum[i]  = 0;
      end
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WARMUP) warmup_limit = cfg_data[WARM_W-1:0];
        else if (cfg_index == REG_AXIS) axis_reg = cfg_data[AXIS_W-1:0];
      end
      // retire results before taking this edge's request
      if (out_valid && !out_stall) begin
        seen_r.angle[0] = out_angle_x;
        seen_r.angle[1] = out_angle_y;
        seen_r.angle[2] = out_angle_z;
        seen_r.report   = out_stats_report;
        seen_r.ready    = out_stats_ready;
        seen_r.min_v    = out_stat_min;
        seen_r.avg_v    = out_stat_avg;
        seen_r.max_v    = out_stat_max;
        if (expected_reports.size() == 0) begin
          errs++;
          if (errs <= MAX_PRINT)
            $display("%0t: result with no request outstanding, actual 0x%0h", $time, seen_r);
        end else begin
          want_r = expected_reports.pop_front();
          check_field("angle_x", want_r.angle[0], seen_r.angle[0]);
          check_field("angle_y", want_r.angle[1], seen_r.angle[1]);
          check_field("angle_z", want_r.angle[2], seen_r.angle[2]);
          check_field("stats_report", want_r.report, seen_r.report);
          check_field("stats_ready", want_r.ready, seen_r.ready);
          check_field("stat_min", want_r.min_v, seen_r.min_v);
          check_field("stat_avg", want_r.avg_v, seen_r.avg_v);
          check_field("stat_max", want_r.max_v, seen_r.max_v);
        end
      end
      if (in_valid && !in_stall)
        expected_reports.push_back(track_request(in_gyro_vld,
                                                 {in_gyro_z, in_gyro_y, in_gyro_x},
                                                 in_mag_vld,
                                                 {in_mag_z, in_mag_y, in_mag_x}));
    end
    pending    <= expected_reports.size();
    fail_count <= errs;
  end

endmodule

FILE: dv/tb.sv
// Testbench top: drives requests and register writes into the tracker and reports the verdict.
`timescale 1ns / 1ps

module tb;
  import gamt_pkg::*;

  localparam int GYRO_W         = FRAC_BITS_DEF + GYRO_EXTRA;
  localparam int ANGLE_W        = FRAC_BITS_DEF + ANGLE_EXTRA;
  localparam int MAG_W          = MAG_WIDTH_DEF;
  localparam int GYRO_MAX       = (TURN_DEG << FRAC_BITS_DEF) - 1;
  localparam int MAG_MAX        = (1 << (MAG_W - 1)) - 1;
  localparam int MAG_MIN        = -(1 << (MAG_W - 1));
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 2 * (MAG_W + 4);
  localparam int WATCHDOG_LIMIT = 5000;
  localparam axis_sel_t AXIS_X   = 2'd0;
  localparam axis_sel_t AXIS_BAD = 2'd3;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_gyro_vld;
  logic signed [GYRO_W-1:0]  in_gyro_x;
  logic signed [GYRO_W-1:0]  in_gyro_y;
  logic signed [GYRO_W-1:0]  in_gyro_z;
  logic                      in_mag_vld;
  logic signed [MAG_W-1:0]   in_mag_x;
  logic signed [MAG_W-1:0]   in_mag_y;
  logic signed [MAG_W-1:0]   in_mag_z;
  logic                      out_valid;
  logic                      out_stall;
  logic [ANGLE_W-1:0]        out_angle_x;
  logic [ANGLE_W-1:0]        out_angle_y;
  logic [ANGLE_W-1:0]        out_angle_z;
  logic                      out_stats_report;
  logic                      out_stats_ready;
  logic signed [MAG_W-1:0]   out_stat_min;
  logic signed [MAG_W-1:0]   out_stat_avg;
  logic signed [MAG_W-1:0]   out_stat_max;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int quiet_cycles;

  gyro_angle_and_mag_range_tracker i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_gyro_vld      (in_gyro_vld),
    .in_gyro_x        (in_gyro_x),
    .in_gyro_y        (in_gyro_y),
    .in_gyro_z        (in_gyro_z),
    .in_mag_vld       (in_mag_vld),
    .in_mag_x         (in_mag_x),
    .in_mag_y         (in_mag_y),
    .in_mag_z         (in_mag_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_angle_x      (out_angle_x),
    .out_angle_y      (out_angle_y),
    .out_angle_z      (out_angle_z),
    .out_stats_report (out_stats_report),
    .out_stats_ready  (out_stats_ready),
    .out_stat_min     (out_stat_min),
    .out_stat_avg     (out_stat_avg),
    .out_stat_max     (out_stat_max),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  gamt_checker i_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_gyro_vld      (in_gyro_vld),
    .in_gyro_x        (in_gyro_x),
    .in_gyro_y        (in_gyro_y),
    .in_gyro_z        (in_gyro_z),
    .in_mag_vld       (in_mag_vld),
    .in_mag_x         (in_mag_x),
    .in_mag_y         (in_mag_y),
    .in_mag_z         (in_mag_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_angle_x      (out_angle_x),
    .out_angle_y      (out_angle_y),
    .out_angle_z      (out_angle_z),
    .out_stats_report (out_stats_report),
    .out_stats_ready  (out_stats_ready),
    .out_stat_min     (out_stat_min),
    .out_stat_avg     (out_stat_avg),
    .out_stat_max     (out_stat_max),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stall, or one long hold-off when asked.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [GYRO_W-1:0] pick_gyro();
    case ($urandom_range(7))
      0:       return GYRO_W'(GYRO_MAX);
      1:       return GYRO_W'(-GYRO_MAX);
      2, 3:    return GYRO_W'($urandom_range(2000) - 1000);
      default: return GYRO_W'($urandom_range(2 * GYRO_MAX) - GYRO_MAX);
    endcase
  endfunction

  function automatic logic signed [MAG_W-1:0] pick_mag();
    case ($urandom_range(7))
      0:       return MAG_W'(MAG_MAX);
      1:       return MAG_W'(MAG_MIN);
      2, 3, 4: return MAG_W'($urandom_range(400) - 200);
      default: return MAG_W'($urandom);
    endcase
  endfunction

  // Offer one request after a random idle gap; return at the accepting edge.
  task automatic send_request(
    input logic                     imu,
    input logic signed [GYRO_W-1:0] gx,
    input logic signed [GYRO_W-1:0] gy,
    input logic signed [GYRO_W-1:0] gz,
    input logic                     mag,
    input logic signed [MAG_W-1:0]  mx,
    input logic signed [MAG_W-1:0]  my,
    input logic signed [MAG_W-1:0]  mz
  );
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_gyro_vld  <= imu;
    in_gyro_x    <= gx;
    in_gyro_y    <= gy;
    in_gyro_z    <= gz;
    in_mag_vld   <= mag;
    in_mag_x     <= mx;
    in_mag_y     <= my;
    in_mag_z     <= mz;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [WARM_W-1:0] warmup, input axis_sel_t axis);
    put_reg(REG_WARMUP, warmup);
    put_reg(REG_AXIS, CFG_DATA_W'(axis));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n, input int idle, input int stall, input bit hold);
    idle_pct  = idle;
    stall_pct = stall;
    hold_req  = hold;
    repeat (n)
      send_request($urandom_range(3) != 0, pick_gyro(), pick_gyro(), pick_gyro(),
                   $urandom_range(4) < 3, pick_mag(), pick_mag(), pick_mag());
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_gyro_vld  = 1'b0;
    in_gyro_x    = '0;
    in_gyro_y    = '0;
    in_gyro_z    = '0;
    in_mag_vld   = 1'b0;
    in_mag_x     = '0;
    in_mag_y     = '0;
    in_mag_z     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_WARMUP;
    cfg_data     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: samples still in warmup, stats not ready
    send_request(1'b0, GYRO_MAX, -GYRO_MAX, 1, 1'b0, MAG_MAX, MAG_MIN, -1);
    send_request(1'b1, GYRO_MAX, GYRO_MAX, GYRO_MAX, 1'b0, 0, 0, 0);
    send_request(1'b1, -GYRO_MAX, -GYRO_MAX, -GYRO_MAX, 1'b0, 0, 0, 0);
    send_request(1'b1, -GYRO_MAX, GYRO_MAX, -1, 1'b0, 0, 0, 0);
    send_request(1'b1, -1, 1, GYRO_MAX, 1'b0, 0, 0, 0);
    send_request(1'b0, 0, 0, 0, 1'b1, MAG_MAX, MAG_MIN, 0);
    send_request(1'b1, 12345, -54321, 0, 1'b1, MAG_MIN, MAG_MAX, 1);
    drain();

    // no warmup: next sample is the first counted one
    configure('0, AXIS_X);
    send_request(1'b0, 0, 0, 0, 1'b1, MAG_MIN, MAG_MAX, 1);
    send_request(1'b1, 7, -7, 0, 1'b1, MAG_MAX, MAG_MIN, -1);
    send_request(1'b0, 0, 0, 0, 1'b1, -3, -4, -5);
    send_request(1'b1, GYRO_MAX, -GYRO_MAX, GYRO_MAX, 1'b0, MAG_MAX, MAG_MAX, MAG_MAX);
    drain();
    configure('0, AXIS_BAD);
    send_request(1'b0, 0, 0, 0, 1'b1, 7, 8, 9);
    drain();
    configure('0, AXIS_Z);
    send_request(1'b1, 1, 2, 3, 1'b0, 0, 0, 0);
    drain();
    configure('0, AXIS_Y);
    send_request(1'b0, 0, 0, 0, 1'b1, -100, 100, 0);
    drain();

    // raised warmup ignores samples again until the count catches up
    configure(WARM_W'(20), AXIS_Y);
    run_random(150, 0, 0, 1'b0);
    configure('1, AXIS_Z);
    run_random(150, 77, 0, 1'b0);
    configure(WARM_W'(5), AXIS_X);
    run_random(150, 0, 77, 1'b0);
    configure(WARMUP_RESET, AXIS_Y);
    run_random(150, 77, 77, 1'b0);
    // long receiver hold-off while requests keep coming
    configure('0, AXIS_Z);
    run_random(120, 0, 0, 1'b1);
    configure(WARM_W'(300), AXIS_X);
    run_random(215, 10, 10, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
